### hw/rtl/tpps_pkg.sv
// Shared types, constants and elaboration-time tables for the TAN pixel-to-sky block.
// Used by tpps_mul, tpps_vec, tan_projection_pixel_to_sky, tpps_checker and testbench; depends on nothing.
`default_nettype none

package tpps_pkg;

  // One input word and one result word.
  typedef struct packed {
    logic signed [31:0] pix_x;
    logic signed [31:0] pix_y;
  } pix_t;

  typedef struct packed {
    logic signed [42:0] sky_ra;
    logic signed [39:0] sky_dec;
  } sky_t;

  // Pipeline geometry.
  localparam int STEPS   = 60;
  localparam int MUL_LAT = 4;
  localparam int VEC_LAT = STEPS + 1;
  localparam int ADDR_W  = 6;

  // Register indexes on the configuration port.
  localparam logic [2:0] IDX_REF_PIXEL_X = 3'd0;
  localparam logic [2:0] IDX_REF_PIXEL_Y = 3'd1;
  localparam logic [2:0] IDX_REF_RA      = 3'd2;
  localparam logic [2:0] IDX_REF_DEC     = 3'd3;
  localparam logic [2:0] IDX_SCALE_11    = 3'd4;
  localparam logic [2:0] IDX_SCALE_12    = 3'd5;
  localparam logic [2:0] IDX_SCALE_21    = 3'd6;
  localparam logic [2:0] IDX_SCALE_22    = 3'd7;

  // Sequencer that derives sin and cos of the reference declination.
  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_ZMUL,
    SEQ_ZWAIT,
    SEQ_ROT,
    SEQ_AMUL,
    SEQ_BMUL,
    SEQ_ABWAIT
  } seq_state_e;

  // Angle and range constants (2^-32 degree for the ranges).
  localparam logic [63:0]        PI_Q60    = 64'h3243F6A8885A308D;
  localparam logic signed [63:0] HALF_PI   = $signed(PI_Q60 >> 1);
  localparam logic signed [63:0] DEG90     = 64'sd386547056640;
  localparam logic signed [63:0] RA_LO     = -64'sd773094113280;
  localparam logic signed [63:0] RA_HI     = 64'sd2319282339840;
  localparam logic signed [63:0] ONE_Q60   = 64'sd1 <<< 60;

  // pi/180 scaled by 2^68 and 180/pi scaled by 2^57, both truncated.
  localparam logic [127:0] PIO180_W = ({64'd0, PI_Q60} << 8) / 128'd180;
  localparam logic [127:0] K180_W   = (128'd180 << 117) / {64'd0, PI_Q60};
  localparam logic signed [63:0] PIO180 = $signed(PIO180_W[63:0]);
  localparam logic signed [63:0] K180   = $signed(K180_W[63:0]);
  localparam logic signed [63:0] R_UNIT = K180 >>> 25;

  typedef logic [STEPS-1:0][63:0] atan_tab_t;

  // Restoring long division, only evaluated while building constants.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], num[b]};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) in Q60 from the truncated alternating series.
  function automatic atan_tab_t build_atan();
    atan_tab_t         tab;
    logic signed [63:0] sum;
    logic signed [63:0] term;
    int                 e;
    tab[0] = PI_Q60 >> 2;
    for (int i = 1; i < STEPS; i++) begin
      sum = '0;
      for (int k = 0; k < 31; k++) begin
        e = 60 - i * (2 * k + 1);
        if (e >= 0) begin
          term = $signed(udiv64(64'd1 << e, 64'(2 * k + 1)));
          if ((k & 1) == 1) begin
            sum = sum - term;
          end else begin
            sum = sum + term;
          end
        end
      end
      tab[i] = sum;
    end
    return tab;
  endfunction

  localparam atan_tab_t ATAN_TAB = build_atan();

  // CORDIC gain: x result of a rotation by zero starting at one.
  function automatic logic signed [63:0] cordic_gain();
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] z;
    logic signed [63:0] nx;
    x = ONE_Q60;
    y = '0;
    z = '0;
    for (int i = 0; i < STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - $signed(ATAN_TAB[i]);
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + $signed(ATAN_TAB[i]);
      end
      x = nx;
    end
    return x;
  endfunction

  localparam logic signed [63:0] GAIN_Q60 = cordic_gain();

endpackage

`default_nettype wire

### hw/rtl/tpps_mul.sv
// Pipelined signed multiply with magnitude truncation, shift and saturation.
// Four stages built from 32x32 partial products; uses tpps_pkg.
`default_nettype none

module tpps_mul import tpps_pkg::*; #(
  parameter int SHIFT  = 60,
  parameter int SIDE_W = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic signed [63:0]  a_i,
  input  logic signed [63:0]  b_i,
  input  logic [SIDE_W-1:0]   side_i,
  output logic                valid_o,
  output logic signed [63:0]  p_o,
  output logic [SIDE_W-1:0]   side_o
);

  logic [63:0]       ua_q, ub_q;
  logic [63:0]       ll_q, lh_q, hl_q, hh_q;
  logic [127:0]      prod_q;
  logic signed [63:0] p_q;
  logic              neg_q [MUL_LAT-1];
  logic              v_q [MUL_LAT];
  logic [SIDE_W-1:0] side_q [MUL_LAT];
  logic [191:0]      prod_ext;
  logic [63:0]       mag;
  logic [63:0]       mag_sat;

  // Valid bits travel alongside the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MUL_LAT; k++) v_q[k] <= 1'b0;
    end else begin
      v_q[0] <= valid_i;
      for (int k = 1; k < MUL_LAT; k++) v_q[k] <= v_q[k-1];
    end
  end

  // Magnitudes and the sign of the product.
  always_ff @(posedge clk_i) begin
    ua_q      <= a_i[63] ? 64'(-a_i) : 64'(a_i);
    ub_q      <= b_i[63] ? 64'(-b_i) : 64'(b_i);
    neg_q[0]  <= a_i[63] ^ b_i[63];
    side_q[0] <= side_i;
    for (int k = 1; k < MUL_LAT; k++) side_q[k] <= side_q[k-1];
    for (int k = 1; k < MUL_LAT - 1; k++) neg_q[k] <= neg_q[k-1];
  end

  // Partial products.
  always_ff @(posedge clk_i) begin
    ll_q <= 64'(ua_q[31:0]) * 64'(ub_q[31:0]);
    lh_q <= 64'(ua_q[31:0]) * 64'(ub_q[63:32]);
    hl_q <= 64'(ua_q[63:32]) * 64'(ub_q[31:0]);
    hh_q <= 64'(ua_q[63:32]) * 64'(ub_q[63:32]);
  end

  // Full 128-bit magnitude product.
  always_ff @(posedge clk_i) begin
    prod_q <= {64'd0, ll_q} + {32'd0, lh_q, 32'd0} + {32'd0, hl_q, 32'd0} + {hh_q, 64'd0};
  end

  // Shift, saturate to the positive range and restore the sign.
  assign prod_ext = {64'd0, prod_q};
  assign mag      = prod_ext[SHIFT +: 64];
  assign mag_sat  = mag[63] ? 64'h7FFF_FFFF_FFFF_FFFF : mag;

  always_ff @(posedge clk_i) begin
    p_q <= neg_q[MUL_LAT-2] ? $signed(-mag_sat) : $signed(mag_sat);
  end

  assign valid_o = v_q[MUL_LAT-1];
  assign p_o     = p_q;
  assign side_o  = side_q[MUL_LAT-1];

endmodule

`default_nettype wire

### hw/rtl/tpps_vec.sv
// Fully pipelined CORDIC vectoring unit: angle and magnitude of (x, y), one step a stage.
// Uses the arctangent constants of tpps_pkg.
`default_nettype none

module tpps_vec import tpps_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic signed [63:0]  x_i,
  input  logic signed [63:0]  y_i,
  input  logic [SIDE_W-1:0]   side_i,
  output logic                valid_o,
  output logic signed [63:0]  ang_o,
  output logic signed [63:0]  mag_o,
  output logic [SIDE_W-1:0]   side_o
);

  logic signed [63:0] x_q [VEC_LAT];
  logic signed [63:0] y_q [VEC_LAT];
  logic signed [63:0] z_q [VEC_LAT];
  logic               zf_q [VEC_LAT];
  logic               v_q [VEC_LAT];
  logic [SIDE_W-1:0]  side_q [VEC_LAT];
  logic signed [63:0] x0_d, y0_d, z0_d;

  // Pre-rotation by a quarter turn brings x into the right half plane.
  always_comb begin
    x0_d = x_i;
    y0_d = y_i;
    z0_d = '0;
    if (x_i[63]) begin
      if (!y_i[63]) begin
        x0_d = y_i;
        y0_d = -x_i;
        z0_d = HALF_PI;
      end else begin
        x0_d = -y_i;
        y0_d = x_i;
        z0_d = -HALF_PI;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q[0]    <= x0_d;
    y_q[0]    <= y0_d;
    z_q[0]    <= z0_d;
    zf_q[0]   <= (x_i == 64'sd0) && (y_i == 64'sd0);
    side_q[0] <= side_i;
  end

  // One micro-rotation per stage; the sign of y picks the direction.
  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [63:0] xs, ys;
    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else begin
        v_q[i+1] <= v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (!y_q[i][63]) begin
        x_q[i+1] <= x_q[i] + ys;
        y_q[i+1] <= y_q[i] - xs;
        z_q[i+1] <= z_q[i] + $signed(ATAN_TAB[i]);
      end else begin
        x_q[i+1] <= x_q[i] - ys;
        y_q[i+1] <= y_q[i] + xs;
        z_q[i+1] <= z_q[i] - $signed(ATAN_TAB[i]);
      end
      zf_q[i+1]   <= zf_q[i];
      side_q[i+1] <= side_q[i];
    end
  end

  // A zero vector has angle zero and magnitude zero.
  assign valid_o = v_q[STEPS];
  assign ang_o   = zf_q[STEPS] ? 64'sd0 : z_q[STEPS];
  assign mag_o   = zf_q[STEPS] ? 64'sd0 : x_q[STEPS];
  assign side_o  = side_q[STEPS];

endmodule

`default_nettype wire

### hw/rtl/tan_projection_pixel_to_sky.sv
// Top level of the gnomonic (TAN) pixel-to-sky converter: APB registers, sin/cos
// sequencer and the item pipeline. Depends on tpps_pkg, tpps_mul and tpps_vec.
//
// Channel   | Direction | Handshake                  | Word
// ----------+-----------+----------------------------+-------------------------
// pixel in  | input     | start high and busy low    | pix_i  (pix_x, pix_y)
// sky out   | output    | done_o strobe, one cycle   | sky_o  (sky_ra, sky_dec)
// config    | input     | APB write, pready always 1 | pwdata at paddr[5:3]
//
// One word enters per cycle while busy is low; its result is registered on sky_o
// together with done_o after the offset, matrix, vectoring and conversion stages.
// After reset, and after each write of ref_dec, busy is high while a 60-step
// iterative CORDIC derives sin and cos of the reference declination.
// The receiver cannot stall, so the pipeline never holds; valid bits travel with data.
`default_nettype none

module tan_projection_pixel_to_sky import tpps_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  pix_t              pix_i,
  output logic              done_o,
  output sky_t              sky_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);

  // ---------------------------------------------------------------- registers
  logic signed [31:0] ref_pixel_x_q, ref_pixel_y_q;
  logic [40:0]        ref_ra_q;
  logic signed [39:0] ref_dec_q;
  logic signed [47:0] scale_11_q, scale_12_q, scale_21_q, scale_22_q;
  logic               cfg_we;
  logic [2:0]         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign cfg_idx = paddr[5:3];

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_pixel_x_q <= '0;
      ref_pixel_y_q <= '0;
      ref_ra_q      <= '0;
      ref_dec_q     <= '0;
      scale_11_q    <= '0;
      scale_12_q    <= '0;
      scale_21_q    <= '0;
      scale_22_q    <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        IDX_REF_PIXEL_X: ref_pixel_x_q <= pwdata[31:0];
        IDX_REF_PIXEL_Y: ref_pixel_y_q <= pwdata[31:0];
        IDX_REF_RA:      ref_ra_q      <= pwdata[40:0];
        IDX_REF_DEC:     ref_dec_q     <= pwdata[39:0];
        IDX_SCALE_11:    scale_11_q    <= pwdata[47:0];
        IDX_SCALE_12:    scale_12_q    <= pwdata[47:0];
        IDX_SCALE_21:    scale_21_q    <= pwdata[47:0];
        IDX_SCALE_22:    scale_22_q    <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    case (cfg_idx)
      IDX_REF_PIXEL_X: prdata = {32'd0, ref_pixel_x_q};
      IDX_REF_PIXEL_Y: prdata = {32'd0, ref_pixel_y_q};
      IDX_REF_RA:      prdata = {23'd0, ref_ra_q};
      IDX_REF_DEC:     prdata = {24'd0, ref_dec_q};
      IDX_SCALE_11:    prdata = {16'd0, scale_11_q};
      IDX_SCALE_12:    prdata = {16'd0, scale_12_q};
      IDX_SCALE_21:    prdata = {16'd0, scale_21_q};
      IDX_SCALE_22:    prdata = {16'd0, scale_22_q};
      default:         prdata = '0;
    endcase
  end

  // Reference declination limited to the poles.
  logic signed [63:0] dec_ext, d0;
  assign dec_ext = {{24{ref_dec_q[39]}}, ref_dec_q};
  assign d0 = (dec_ext > DEG90) ? DEG90 : ((dec_ext < -DEG90) ? -DEG90 : dec_ext);

  // ---------------------------------------------------------------- sequencer
  seq_state_e         state_q, state_d;
  logic [5:0]         cnt_q;
  logic signed [63:0] zr_q, cg_q, sg_q, a0_q, b0_q;
  logic signed [63:0] zmul_p, amul_p, amul_b;
  logic signed [63:0] rot_xs, rot_ys, rot_atan;

  // Degrees to Q60 radians for the rotation angle.
  tpps_mul #(.SHIFT(40), .SIDE_W(1)) u_mul_z (
    .clk_i, .rst_ni,
    .valid_i (state_q == SEQ_ZMUL),
    .a_i     (d0),
    .b_i     (PIO180),
    .side_i  (1'b0),
    .valid_o (),
    .p_o     (zmul_p),
    .side_o  ()
  );

  // R cos d0 and R sin d0, issued on back-to-back cycles.
  assign amul_b = (state_q == SEQ_AMUL) ? cg_q : sg_q;

  tpps_mul #(.SHIFT(60), .SIDE_W(1)) u_mul_r (
    .clk_i, .rst_ni,
    .valid_i (state_q == SEQ_AMUL),
    .a_i     (R_UNIT),
    .b_i     (amul_b),
    .side_i  (1'b0),
    .valid_o (),
    .p_o     (amul_p),
    .side_o  ()
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      SEQ_IDLE:   state_d = SEQ_IDLE;
      SEQ_ZMUL:   state_d = SEQ_ZWAIT;
      SEQ_ZWAIT:  if (cnt_q == 6'(MUL_LAT - 1)) state_d = SEQ_ROT;
      SEQ_ROT:    if (cnt_q == 6'(STEPS - 1)) state_d = SEQ_AMUL;
      SEQ_AMUL:   state_d = SEQ_BMUL;
      SEQ_BMUL:   state_d = SEQ_ABWAIT;
      SEQ_ABWAIT: if (cnt_q == 6'(MUL_LAT - 1)) state_d = SEQ_IDLE;
      default:    state_d = SEQ_IDLE;
    endcase
    if (cfg_we && (cfg_idx == IDX_REF_DEC)) begin
      state_d = SEQ_ZMUL;
    end
  end

  // Outputs of the sequencer.
  always_comb begin
    case (state_q)
      SEQ_IDLE: busy = 1'b0;
      default:  busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_ZMUL;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        SEQ_ZWAIT, SEQ_ABWAIT: cnt_q <= (cnt_q == 6'(MUL_LAT - 1)) ? 6'd0 : cnt_q + 6'd1;
        SEQ_ROT:               cnt_q <= (cnt_q == 6'(STEPS - 1)) ? 6'd0 : cnt_q + 6'd1;
        default:               cnt_q <= '0;
      endcase
    end
  end

  // Rotation datapath: one CORDIC step per cycle.
  assign rot_xs   = cg_q >>> cnt_q;
  assign rot_ys   = sg_q >>> cnt_q;
  assign rot_atan = $signed(ATAN_TAB[cnt_q]);

  always_ff @(posedge clk_i) begin
    case (state_q)
      SEQ_ZWAIT: begin
        if (cnt_q == 6'(MUL_LAT - 1)) begin
          zr_q <= zmul_p;
          cg_q <= ONE_Q60;
          sg_q <= '0;
        end
      end
      SEQ_ROT: begin
        if (!zr_q[63]) begin
          cg_q <= cg_q - rot_ys;
          sg_q <= sg_q + rot_xs;
          zr_q <= zr_q - rot_atan;
        end else begin
          cg_q <= cg_q + rot_ys;
          sg_q <= sg_q - rot_xs;
          zr_q <= zr_q + rot_atan;
        end
      end
      SEQ_ABWAIT: begin
        if (cnt_q == 6'(MUL_LAT - 2)) a0_q <= amul_p;
        if (cnt_q == 6'(MUL_LAT - 1)) b0_q <= amul_p;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- pipeline
  logic               acc;
  logic               v0_q, v1_q, v2_q, done_q;
  logic signed [63:0] dx_q, dy_q, px_q, py_q;
  logic signed [63:0] a_q, b_q, pxg_q;
  logic               nz2_q;
  sky_t               sky_q;

  assign acc = start & ~busy;

  // Offsets from the reference pixel.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q <= {{32{pix_i.pix_x[31]}}, pix_i.pix_x} - {{32{ref_pixel_x_q[31]}}, ref_pixel_x_q};
    dy_q <= {{32{pix_i.pix_y[31]}}, pix_i.pix_y} - {{32{ref_pixel_y_q[31]}}, ref_pixel_y_q};
  end

  // CD matrix products.
  logic               ma_v;
  logic signed [63:0] p11, p12, p21, p22;

  tpps_mul #(.SHIFT(26), .SIDE_W(1)) u_mul_11 (
    .clk_i, .rst_ni, .valid_i(v0_q), .a_i(dx_q),
    .b_i({{16{scale_11_q[47]}}, scale_11_q}), .side_i(1'b0),
    .valid_o(ma_v), .p_o(p11), .side_o()
  );
  tpps_mul #(.SHIFT(26), .SIDE_W(1)) u_mul_12 (
    .clk_i, .rst_ni, .valid_i(v0_q), .a_i(dy_q),
    .b_i({{16{scale_12_q[47]}}, scale_12_q}), .side_i(1'b0),
    .valid_o(), .p_o(p12), .side_o()
  );
  tpps_mul #(.SHIFT(26), .SIDE_W(1)) u_mul_21 (
    .clk_i, .rst_ni, .valid_i(v0_q), .a_i(dx_q),
    .b_i({{16{scale_21_q[47]}}, scale_21_q}), .side_i(1'b0),
    .valid_o(), .p_o(p21), .side_o()
  );
  tpps_mul #(.SHIFT(26), .SIDE_W(1)) u_mul_22 (
    .clk_i, .rst_ni, .valid_i(v0_q), .a_i(dy_q),
    .b_i({{16{scale_22_q[47]}}, scale_22_q}), .side_i(1'b0),
    .valid_o(), .p_o(p22), .side_o()
  );

  // Plane coordinates.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= ma_v;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q <= p11 + p12;
    py_q <= p21 + p22;
  end

  // Rotation terms and the gain-matched x coordinate.
  logic               nz1;
  logic               mb_v, nzb;
  logic signed [63:0] t_sg, t_cg, pxg;

  assign nz1 = (|px_q) | (|py_q);

  tpps_mul #(.SHIFT(60), .SIDE_W(1)) u_mul_pysg (
    .clk_i, .rst_ni, .valid_i(v1_q), .a_i(py_q), .b_i(sg_q), .side_i(nz1),
    .valid_o(mb_v), .p_o(t_sg), .side_o(nzb)
  );
  tpps_mul #(.SHIFT(60), .SIDE_W(1)) u_mul_pycg (
    .clk_i, .rst_ni, .valid_i(v1_q), .a_i(py_q), .b_i(cg_q), .side_i(1'b0),
    .valid_o(), .p_o(t_cg), .side_o()
  );
  tpps_mul #(.SHIFT(60), .SIDE_W(1)) u_mul_pxg (
    .clk_i, .rst_ni, .valid_i(v1_q), .a_i(px_q), .b_i(GAIN_Q60), .side_i(1'b0),
    .valid_o(), .p_o(pxg), .side_o()
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= mb_v;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a0_q - t_sg;
    b_q   <= b0_q + t_cg;
    pxg_q <= pxg;
    nz2_q <= nzb;
  end

  // Gain match of the declination numerator; a and px ride along.
  logic               mc_v;
  logic signed [63:0] bg;
  logic [128:0]       side_c;

  tpps_mul #(.SHIFT(60), .SIDE_W(129)) u_mul_bg (
    .clk_i, .rst_ni, .valid_i(v2_q), .a_i(b_q), .b_i(GAIN_Q60),
    .side_i({nz2_q, a_q, pxg_q}),
    .valid_o(mc_v), .p_o(bg), .side_o(side_c)
  );

  // Longitude offset, then declination.
  logic               v1v, v2v;
  logic signed [63:0] off, m1, dr;
  logic [64:0]        side_v1, side_v2;

  tpps_vec #(.SIDE_W(65)) u_vec_ra (
    .clk_i, .rst_ni, .valid_i(mc_v),
    .x_i($signed(side_c[127:64])), .y_i($signed(side_c[63:0])),
    .side_i({side_c[128], bg}),
    .valid_o(v1v), .ang_o(off), .mag_o(m1), .side_o(side_v1)
  );

  tpps_vec #(.SIDE_W(65)) u_vec_dec (
    .clk_i, .rst_ni, .valid_i(v1v),
    .x_i(m1), .y_i($signed(side_v1[63:0])),
    .side_i({side_v1[64], off}),
    .valid_o(v2v), .ang_o(dr), .mag_o(), .side_o(side_v2)
  );

  // Back to 2^-32 degree.
  logic               md_v, nzd;
  logic signed [63:0] off_deg, dec_deg;

  tpps_mul #(.SHIFT(85), .SIDE_W(1)) u_mul_ra (
    .clk_i, .rst_ni, .valid_i(v2v), .a_i($signed(side_v2[63:0])), .b_i(K180),
    .side_i(side_v2[64]),
    .valid_o(md_v), .p_o(off_deg), .side_o(nzd)
  );
  tpps_mul #(.SHIFT(85), .SIDE_W(1)) u_mul_dec (
    .clk_i, .rst_ni, .valid_i(v2v), .a_i(dr), .b_i(K180), .side_i(1'b0),
    .valid_o(), .p_o(dec_deg), .side_o()
  );

  // Add the reference RA, pick the reference point at zero offset, saturate.
  logic signed [63:0] ra_base, ra_raw, dec_raw, ra_sat, dec_sat;

  assign ra_base = $signed({23'd0, ref_ra_q});
  assign ra_raw  = nzd ? (ra_base + off_deg) : ra_base;
  assign dec_raw = nzd ? dec_deg : d0;
  assign ra_sat  = (ra_raw < RA_LO) ? RA_LO : ((ra_raw > RA_HI) ? RA_HI : ra_raw);
  assign dec_sat = (dec_raw < -DEG90) ? -DEG90 : ((dec_raw > DEG90) ? DEG90 : dec_raw);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= md_v;
    end
  end

  always_ff @(posedge clk_i) begin
    sky_q.sky_ra  <= ra_sat[42:0];
    sky_q.sky_dec <= dec_sat[39:0];
  end

  assign done_o = done_q;
  assign sky_o  = sky_q;

`ifndef SYNTH
  // An accepted word enters the first stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni) acc |=> v0_q)
    else $error("accepted word missing from first stage");

  // Declination stays within the poles.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($signed(sky_o.sky_dec) >= -40'sd386547056640 &&
                $signed(sky_o.sky_dec) <= 40'sd386547056640))
    else $error("declination out of range");

  // Right ascension stays within its saturation range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($signed(sky_o.sky_ra) >= -43'sd773094113280 &&
                $signed(sky_o.sky_ra) <= 43'sd2319282339840))
    else $error("right ascension out of range");

  // The sequencer only restarts on a write of the reference declination.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(cfg_we && (cfg_idx == IDX_REF_DEC)))
    else $error("sequencer started without a declination write");
`endif

endmodule

`default_nettype wire

### dv/tpps_checker.sv
// Scoreboard for the TAN pixel-to-sky block: mirrors the register writes, predicts
// each sky word from an accepted pixel word and compares. Depends on tpps_pkg only.
`default_nettype none

module tpps_checker import tpps_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic              busy,
  input  pix_t              pix_i,
  input  logic              done_o,
  input  sky_t              sky_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [63:0]       pwdata,
  input  logic              pready,
  output int                pending,
  output int                fails
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSTEP = 60;

  // Shadow copy of the register file.
  logic signed [31:0] ref_px;
  logic signed [31:0] ref_py;
  logic [40:0]        ref_ra;
  logic signed [39:0] ref_dec;
  logic signed [47:0] cd11, cd12, cd21, cd22;

  // Fixed constants of the projection arithmetic.
  logic signed [63:0] arctan_q60 [NSTEP];
  logic signed [63:0] deg_to_rad;
  logic signed [63:0] rad_to_deg;
  logic signed [63:0] deg_per_rad;
  logic signed [63:0] cordic_k;

  sky_t expected_sky [$];

  // Product with its magnitude shifted right, truncated toward zero, saturated.
  function automatic logic signed [63:0] mul_trunc(input logic signed [63:0] a,
                                                   input logic signed [63:0] b,
                                                   input int n);
    logic [63:0]  ua, ub;
    logic [127:0] p;
    logic [63:0]  m;
    ua = a[63] ? 64'(-a) : a;
    ub = b[63] ? 64'(-b) : b;
    p = {64'd0, ua} * {64'd0, ub};
    p = p >> n;
    m = (p > 128'h7FFF_FFFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF_FFFF : p[63:0];
    return (a[63] != b[63]) ? -$signed(m) : $signed(m);
  endfunction

  task automatic cordic_rotate(input logic signed [63:0] ang,
                               output logic signed [63:0] c,
                               output logic signed [63:0] s);
    logic signed [63:0] x, y, z, nx;
    x = 64'sd1 <<< 60;
    y = 0;
    z = ang;
    for (int i = 0; i < NSTEP; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - arctan_q60[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + arctan_q60[i];
      end
      x = nx;
    end
    c = x;
    s = y;
  endtask

  // Angle of (x, y) with a quarter-turn pre-rotation for negative x.
  task automatic cordic_angle(input logic signed [63:0] xi,
                              input logic signed [63:0] yi,
                              output logic signed [63:0] ang,
                              output logic signed [63:0] mag);
    logic signed [63:0] x, y, z, t;
    x = xi;
    y = yi;
    z = 0;
    if (x == 0 && y == 0) begin
      ang = 0;
      mag = 0;
    end else begin
      if (x < 0) begin
        t = x;
        if (y >= 0) begin
          x = y;
          y = -t;
          z = $signed(PI_Q60 >> 1);
        end else begin
          x = -y;
          y = t;
          z = -$signed(PI_Q60 >> 1);
        end
      end
      for (int i = 0; i < NSTEP; i++) begin
        if (y >= 0) begin
          t = x + (y >>> i);
          y = y - (x >>> i);
          z = z + arctan_q60[i];
        end else begin
          t = x - (y >>> i);
          y = y + (x >>> i);
          z = z - arctan_q60[i];
        end
        x = t;
      end
      ang = z;
      mag = x;
    end
  endtask

  task automatic project_pixel(input pix_t w, output sky_t r);
    logic signed [63:0] dx, dy, px, py, d0, ra, dec;
    logic signed [63:0] cg, sg, a, b, pxg, m1, m2, off, dr;
    dx = 64'(w.pix_x) - 64'(ref_px);
    dy = 64'(w.pix_y) - 64'(ref_py);
    px = mul_trunc(dx, 64'(cd11), 26) + mul_trunc(dy, 64'(cd12), 26);
    py = mul_trunc(dx, 64'(cd21), 26) + mul_trunc(dy, 64'(cd22), 26);
    d0 = 64'(ref_dec);
    if (d0 > DEG90) d0 = DEG90;
    if (d0 < -DEG90) d0 = -DEG90;
    ra = $signed({23'd0, ref_ra});
    dec = d0;
    if (px != 0 || py != 0) begin
      cordic_rotate(mul_trunc(d0, deg_to_rad, 40), cg, sg);
      a = mul_trunc(deg_per_rad, cg, 60) - mul_trunc(py, sg, 60);
      b = mul_trunc(deg_per_rad, sg, 60) + mul_trunc(py, cg, 60);
      pxg = mul_trunc(px, cordic_k, 60);
      cordic_angle(a, pxg, off, m1);
      cordic_angle(m1, mul_trunc(b, cordic_k, 60), dr, m2);
      ra = ra + mul_trunc(off, rad_to_deg, 85);
      dec = mul_trunc(dr, rad_to_deg, 85);
    end
    if (ra < RA_LO) ra = RA_LO;
    if (ra > RA_HI) ra = RA_HI;
    if (dec < -DEG90) dec = -DEG90;
    if (dec > DEG90) dec = DEG90;
    r.sky_ra = ra[42:0];
    r.sky_dec = dec[39:0];
  endtask

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    fails++;
  endtask

  // Build the arctangent table and scale factors once.
  initial begin
    logic signed [63:0] sum, term, c, s;
    logic [127:0]       q;
    int                 e;
    fails = 0;
    arctan_q60[0] = $signed(PI_Q60 >> 2);
    for (int i = 1; i < NSTEP; i++) begin
      sum = 0;
      for (int k = 0; k < 40; k++) begin
        e = 60 - i * (2 * k + 1);
        if (e >= 0) begin
          term = $signed((64'd1 << e) / 64'(2 * k + 1));
          sum = (k % 2 == 1) ? sum - term : sum + term;
        end
      end
      arctan_q60[i] = sum;
    end
    q = ({64'd0, PI_Q60} << 8) / 128'd180;
    deg_to_rad = $signed(q[63:0]);
    q = (128'd180 << 117) / {64'd0, PI_Q60};
    rad_to_deg = $signed(q[63:0]);
    deg_per_rad = rad_to_deg >>> 25;
    cordic_rotate(0, c, s);
    cordic_k = c;
  end

  assign pending = expected_sky.size();

  // Register mirror, prediction on acceptance, comparison on each strobe.
  always @(posedge clk_i or negedge rst_ni) begin
    sky_t want;
    if (!rst_ni) begin
      ref_px <= 0;
      ref_py <= 0;
      ref_ra <= 0;
      ref_dec <= 0;
      cd11 <= 0;
      cd12 <= 0;
      cd21 <= 0;
      cd22 <= 0;
      expected_sky.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[5:3])
          IDX_REF_PIXEL_X: ref_px <= pwdata[31:0];
          IDX_REF_PIXEL_Y: ref_py <= pwdata[31:0];
          IDX_REF_RA:      ref_ra <= pwdata[40:0];
          IDX_REF_DEC:     ref_dec <= pwdata[39:0];
          IDX_SCALE_11:    cd11 <= pwdata[47:0];
          IDX_SCALE_12:    cd12 <= pwdata[47:0];
          IDX_SCALE_21:    cd21 <= pwdata[47:0];
          IDX_SCALE_22:    cd22 <= pwdata[47:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        project_pixel(pix_i, want);
        expected_sky.push_back(want);
      end
      if (done_o) begin
        if (expected_sky.size() == 0) begin
          report_mismatch("sky word with no pixel word pending");
        end else begin
          want = expected_sky.pop_front();
          if (sky_o.sky_ra !== want.sky_ra)
            report_mismatch($sformatf("sky_ra got %0d want %0d", sky_o.sky_ra, want.sky_ra));
          if (sky_o.sky_dec !== want.sky_dec)
            report_mismatch($sformatf("sky_dec got %0d want %0d",
                                      sky_o.sky_dec, want.sky_dec));
        end
      end
    end
  end

endmodule

`default_nettype wire

### dv/testbench.sv
// Top of the TAN pixel-to-sky testbench: clock, reset, register setup and pixel
// stimulus in bursts. Depends on tpps_pkg, tpps_checker and the block itself.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tpps_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [63:0] RA_MAX = 64'd1546188226560;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  pix_t              pix_i;
  logic              done_o;
  sky_t              sky_o;
  logic              psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [63:0]       pwdata, prdata;
  int                pending, fails, cycles;
  logic signed [31:0] cur_ref_x, cur_ref_y;

  tan_projection_pixel_to_sky uut (
    .clk_i, .rst_ni, .start, .busy, .pix_i, .done_o, .sky_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  tpps_checker checker_i (
    .clk_i, .rst_ni, .start, .busy, .pix_i, .done_o, .sky_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready, .pending, .fails
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog on total run length.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Setup and access phases of one register write; starts and ends at a falling edge.
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= ADDR_W'({idx, 3'b000});
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic write_all(input logic [63:0] rx, input logic [63:0] ry,
                           input logic [63:0] ra, input logic [63:0] dec,
                           input logic [63:0] c11, input logic [63:0] c12,
                           input logic [63:0] c21, input logic [63:0] c22);
    write_reg(IDX_REF_PIXEL_X, rx);
    write_reg(IDX_REF_PIXEL_Y, ry);
    write_reg(IDX_REF_RA, ra);
    write_reg(IDX_REF_DEC, dec);
    write_reg(IDX_SCALE_11, c11);
    write_reg(IDX_SCALE_12, c12);
    write_reg(IDX_SCALE_21, c21);
    write_reg(IDX_SCALE_22, c22);
    cur_ref_x = rx[31:0];
    cur_ref_y = ry[31:0];
  endtask

  // Hold one pixel word until it is taken; returns at the falling edge after acceptance.
  // Busy is stable between rising edges, so its value at the falling edge decides
  // the following rising edge.
  task automatic send_pixel(input logic [31:0] x, input logic [31:0] y);
    logic taken;
    start <= 1'b1;
    pix_i <= {x, y};
    taken = 1'b0;
    while (!taken) begin
      taken = !busy;
      @(negedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic send_directed();
    send_pixel(32'd0, 32'd0);
    send_pixel(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_pixel(32'h8000_0000, 32'h8000_0000);
    send_pixel(32'h7FFF_FFFF, 32'h8000_0000);
    send_pixel(32'h8000_0000, 32'h7FFF_FFFF);
    send_pixel(cur_ref_x, cur_ref_y);
    send_pixel(cur_ref_x + 1, cur_ref_y);
    send_pixel(cur_ref_x, cur_ref_y - 1);
    send_pixel(32'hFFFF_FFFF, 32'h0000_0001);
  endtask

  // Random scale entry, magnitudes spread over many octaves.
  function automatic logic [63:0] rand_scale();
    logic signed [47:0] v;
    v = 48'(rand64());
    return 64'($signed(v >>> $urandom_range(0, 40)));
  endfunction

  function automatic logic [63:0] rand_dec();
    logic signed [63:0] d;
    case ($urandom_range(0, 7))
      0: d = DEG90;
      1: d = -DEG90;
      default: d = $signed(rand64() % 64'(2 * DEG90 + 1)) - DEG90;
    endcase
    return d;
  endfunction

  // Mostly offsets near the reference pixel, some anywhere, some exactly on it.
  task automatic send_random_pixel();
    logic [31:0] x, y;
    int          mode;
    mode = $urandom_range(0, 9);
    if (mode <= 5) begin
      x = cur_ref_x + ($signed($urandom) >>> $urandom_range(7, 31));
      y = cur_ref_y + ($signed($urandom) >>> $urandom_range(7, 31));
    end else if (mode <= 8) begin
      x = $urandom;
      y = $urandom;
    end else begin
      x = cur_ref_x;
      y = cur_ref_y;
    end
    send_pixel(x, y);
  endtask

  initial begin
    int left, burst, gap;
    rst_ni = 1'b0;
    start = 1'b0;
    pix_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cycles = 0;
    cur_ref_x = 0;
    cur_ref_y = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset values: every offset collapses to the reference point.
    send_directed();
    drain();

    // Largest positive settings, declination at the pole.
    write_all(64'h7FFF_FFFF, 64'h7FFF_FFFF, RA_MAX, DEG90,
              64'h7FFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF,
              64'h7FFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF);
    send_directed();
    drain();

    // Most negative settings, opposite pole, zero RA.
    write_all(64'h8000_0000, 64'h8000_0000, 64'd0, -DEG90,
              64'h8000_0000_0000, 64'h8000_0000_0000,
              64'h8000_0000_0000, 64'h8000_0000_0000);
    send_directed();
    drain();

    // Reference declination past the poles is clamped.
    write_all(64'd0, 64'd0, 64'd0, 64'h7F_FFFF_FFFF,
              64'd3_000_000_000, 64'd0, 64'd0, 64'd3_000_000_000);
    send_directed();
    drain();
    write_reg(IDX_REF_DEC, 64'h80_0000_0000);
    send_directed();
    drain();

    // Random settings, each phase 125 words in bursts.
    for (int phase = 0; phase < 12; phase++) begin
      write_all(64'($urandom), 64'($urandom), rand64() % (RA_MAX + 1), rand_dec(),
                rand_scale(), rand_scale(), rand_scale(), rand_scale());
      left = 125;
      while (left > 0) begin
        burst = $urandom_range(1, 40);
        if (burst > left) burst = left;
        for (int i = 0; i < burst; i++) send_random_pixel();
        left -= burst;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) begin
          start <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
      end
      drain();
    end

    drain();
    repeat (200) @(negedge clk_i);
    if (fails == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
